FILE: sv/khisn_pkg.sv
// shared types, constants and tables of the keyed tcp isn generator
package khisn_pkg;

    localparam int ROUNDS = 10;
    localparam int STAGES = 4 * ROUNDS;
    localparam int MSG_BYTES = 37;
    localparam int DIGEST_BYTES = 4;
    localparam int BLOCK_BYTES = 64;
    localparam int KEY_MAX = 32;
    localparam logic [31:0] MUL_TIME = 32'd250;

    localparam logic [2:0] REG_KEY0 = 3'd0;
    localparam logic [2:0] REG_KEY1 = 3'd1;
    localparam logic [2:0] REG_KEY2 = 3'd2;
    localparam logic [2:0] REG_KEY3 = 3'd3;
    localparam logic [2:0] REG_LOADED = 3'd4;

    typedef logic [31:0] word_t;
    typedef logic [15:0][31:0] state_t;
    typedef logic [7:0][31:0] xsel_t;

    typedef struct packed {
        state_t m2;
        word_t  base;
        word_t  h1w0;
        logic   missing;
    } side_t;

    localparam word_t IV [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [3:0] SIGMA [10][16] = '{
        '{ 0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15 },
        '{ 14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3 },
        '{ 11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4 },
        '{ 7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8 },
        '{ 9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13 },
        '{ 2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9 },
        '{ 12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11 },
        '{ 13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10 },
        '{ 6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5 },
        '{ 10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0 }
    };

endpackage

FILE: sv/khisn_msg.sv
// input stage: message block assembly and time scaling
module khisn_msg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                key_loaded,
    input  logic                is_ipv6,
    input  logic [63:0]         local_addr_hi,
    input  logic [63:0]         local_addr_lo,
    input  logic [63:0]         remote_addr_hi,
    input  logic [63:0]         remote_addr_lo,
    input  logic [15:0]         own_port,
    input  logic [15:0]         peer_port,
    input  logic [31:0]         time_ms,
    output logic                out_valid,
    output khisn_pkg::side_t    out_side
);
    import khisn_pkg::*;

    logic [7:0] b [BLOCK_BYTES];
    side_t side_next;
    side_t side_reg;
    logic valid_reg;

    always_comb
    begin
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            b[i] = 8'h00;
        end
        b[0] = is_ipv6 ? 8'd6 : 8'd4;
        if (is_ipv6)
        begin
            for (int i = 0; i < 8; i++)
            begin
                b[1 + i]  = local_addr_hi[63 - 8 * i -: 8];
                b[9 + i]  = local_addr_lo[63 - 8 * i -: 8];
                b[17 + i] = remote_addr_hi[63 - 8 * i -: 8];
                b[25 + i] = remote_addr_lo[63 - 8 * i -: 8];
            end
        end
        else
        begin
            b[11] = 8'hFF;
            b[12] = 8'hFF;
            b[27] = 8'hFF;
            b[28] = 8'hFF;
            for (int i = 0; i < 4; i++)
            begin
                b[13 + i] = local_addr_lo[31 - 8 * i -: 8];
                b[29 + i] = remote_addr_lo[31 - 8 * i -: 8];
            end
        end
        b[33] = own_port[15:8];
        b[34] = own_port[7:0];
        b[35] = peer_port[15:8];
        b[36] = peer_port[7:0];
        for (int w = 0; w < 16; w++)
        begin
            side_next.m2[w] = {b[4 * w + 3], b[4 * w + 2], b[4 * w + 1], b[4 * w]};
        end
        side_next.base = time_ms * MUL_TIME;
        side_next.h1w0 = '0;
        side_next.missing = !key_loaded;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg <= side_next;
    end

    assign out_valid = valid_reg;
    assign out_side = side_reg;
endmodule

FILE: sv/khisn_round.sv
// one half round of the compression function: four mixes and a register
module khisn_round (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                diag,
    input  logic                in_valid,
    input  khisn_pkg::state_t   in_v,
    input  khisn_pkg::xsel_t    in_x,
    input  khisn_pkg::side_t    in_side,
    output logic                out_valid,
    output khisn_pkg::state_t   out_v,
    output khisn_pkg::side_t    out_side
);
    import khisn_pkg::*;

    state_t v_next;
    state_t v_reg;
    side_t side_reg;
    logic valid_reg;

    function automatic logic [127:0] mix(word_t a, word_t b, word_t c, word_t d,
                                         word_t x, word_t y);
        word_t ta;
        word_t tb;
        word_t tc;
        word_t td;
        ta = a + b + x;
        td = d ^ ta;
        td = {td[15:0], td[31:16]};
        tc = c + td;
        tb = b ^ tc;
        tb = {tb[11:0], tb[31:12]};
        ta = ta + tb + y;
        td = td ^ ta;
        td = {td[7:0], td[31:8]};
        tc = tc + td;
        tb = tb ^ tc;
        tb = {tb[6:0], tb[31:7]};
        return {ta, tb, tc, td};
    endfunction

    always_comb
    begin
        logic [1:0] ib;
        logic [1:0] ic;
        logic [1:0] id;
        logic [127:0] r;
        v_next = in_v;
        for (int j = 0; j < 4; j++)
        begin
            ib = 2'(j) + (diag ? 2'd1 : 2'd0);
            ic = 2'(j) + (diag ? 2'd2 : 2'd0);
            id = 2'(j) + (diag ? 2'd3 : 2'd0);
            r = mix(in_v[j], in_v[{2'b01, ib}], in_v[{2'b10, ic}], in_v[{2'b11, id}],
                    in_x[2 * j], in_x[2 * j + 1]);
            v_next[j]            = r[127:96];
            v_next[{2'b01, ib}]  = r[95:64];
            v_next[{2'b10, ic}]  = r[63:32];
            v_next[{2'b11, id}]  = r[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_v = v_reg;
    assign out_side = side_reg;
endmodule

FILE: sv/keyed_hash_tcp_isn_generator_unit.sv
// top level of the keyed tcp initial sequence number generator
// One beat enters on any cycle with start high; busy stays low, so a new tuple may follow
// every cycle. Each result shows up with done high after its start beat passes through one
// input stage, forty half-round stages (two keyed blake2s compressions of ten rounds each),
// and one output stage. The receiver cannot stall; each result is on the ports for one
// cycle only. key_missing reflects key_loaded at the time the tuple entered.
module keyed_hash_tcp_isn_generator_unit #(
    parameter int KEY_BYTES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        is_ipv6,
    input  logic [63:0] local_addr_hi,
    input  logic [63:0] local_addr_lo,
    input  logic [63:0] remote_addr_hi,
    input  logic [63:0] remote_addr_lo,
    input  logic [15:0] own_port,
    input  logic [15:0] peer_port,
    input  logic [31:0] time_ms,
    input  logic        write_enable,
    input  logic [2:0]  write_index,
    input  logic [63:0] write_data,
    output logic        done,
    output logic [31:0] isn,
    output logic        key_missing
);
    import khisn_pkg::*;

    localparam int HALF = STAGES / 2;
    localparam int LAT = STAGES + 2;

    logic [63:0] key_reg [4];
    logic key_loaded_reg;
    state_t key_m;
    state_t h0;
    state_t v1_init;

    logic   val_q [STAGES + 1];
    state_t v_q [STAGES + 1];
    side_t  s_q [STAGES + 1];

    logic done_reg;
    logic [31:0] isn_reg;
    logic [31:0] isn_next;
    logic missing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= '0;
            end
            key_loaded_reg <= 1'b0;
        end
        else if (write_enable)
        begin
            unique case (write_index)
                REG_KEY0: key_reg[0] <= write_data;
                REG_KEY1: key_reg[1] <= write_data;
                REG_KEY2: key_reg[2] <= write_data;
                REG_KEY3: key_reg[3] <= write_data;
                REG_LOADED: key_loaded_reg <= write_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        logic [7:0] kb [BLOCK_BYTES];
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            kb[i] = 8'h00;
        end
        for (int i = 0; i < KEY_MAX; i++)
        begin
            if (i < KEY_BYTES)
            begin
                kb[i] = key_reg[i / 8][8 * (i % 8) +: 8];
            end
        end
        for (int w = 0; w < 16; w++)
        begin
            key_m[w] = {kb[4 * w + 3], kb[4 * w + 2], kb[4 * w + 1], kb[4 * w]};
        end
        for (int k = 0; k < 8; k++)
        begin
            h0[k] = IV[k];
            h0[k + 8] = IV[k];
        end
        h0[0] = IV[0] ^ 32'h01010000 ^ (32'(KEY_BYTES) << 8) ^ 32'(DIGEST_BYTES);
        v1_init = h0;
        v1_init[12] = IV[4] ^ 32'(BLOCK_BYTES);
    end

    assign busy = 1'b0;

    khisn_msg u_msg (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (start && !busy),
        .key_loaded     (key_loaded_reg),
        .is_ipv6        (is_ipv6),
        .local_addr_hi  (local_addr_hi),
        .local_addr_lo  (local_addr_lo),
        .remote_addr_hi (remote_addr_hi),
        .remote_addr_lo (remote_addr_lo),
        .own_port       (own_port),
        .peer_port      (peer_port),
        .time_ms        (time_ms),
        .out_valid      (val_q[0]),
        .out_side       (s_q[0])
    );

    assign v_q[0] = v1_init;

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        localparam int RND = (i % HALF) / 2;
        localparam int HF = i % 2;
        state_t v_in;
        side_t s_in;
        xsel_t x_in;
        state_t msrc;

        always_comb
        begin
            state_t h1;
            v_in = v_q[i];
            s_in = s_q[i];
            h1 = v_q[i];
            if (i == HALF)
            begin
                for (int k = 0; k < 8; k++)
                begin
                    h1[k] = h0[k] ^ v_q[i][k] ^ v_q[i][k + 8];
                    v_in[k] = h1[k];
                    v_in[k + 8] = IV[k];
                end
                v_in[12] = IV[4] ^ 32'(BLOCK_BYTES + MSG_BYTES);
                v_in[14] = ~IV[6];
                s_in.h1w0 = h1[0];
            end
            msrc = (i < HALF) ? key_m : s_q[i].m2;
            for (int j = 0; j < 8; j++)
            begin
                x_in[j] = msrc[SIGMA[RND][8 * HF + j]];
            end
        end

        khisn_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .diag      (HF == 1),
            .in_valid  (val_q[i]),
            .in_v      (v_in),
            .in_x      (x_in),
            .in_side   (s_in),
            .out_valid (val_q[i + 1]),
            .out_v     (v_q[i + 1]),
            .out_side  (s_q[i + 1])
        );
    end

    always_comb
    begin
        word_t hw;
        hw = s_q[STAGES].h1w0 ^ v_q[STAGES][0] ^ v_q[STAGES][8];
        isn_next = s_q[STAGES].base + {hw[7:0], hw[15:8], hw[23:16], hw[31:24]};
        if (s_q[STAGES].missing)
        begin
            isn_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= val_q[STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        isn_reg <= isn_next;
        missing_reg <= s_q[STAGES].missing;
    end

    assign done = done_reg;
    assign isn = isn_reg;
    assign key_missing = missing_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result beat missing at fixed latency");

    a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && key_missing) |-> (isn == 32'd0))
        else $error("isn not zero without key");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(val_q[STAGES]))
        else $error("result beat without a tuple in flight");
endmodule
